/* hdl/mail_address_syntax_checker_top_defines.svh */
// ---------------------------------------------------------------------------
// assertion macros shared by the mail address syntax checker checkers
// ---------------------------------------------------------------------------
`ifndef MAIL_ADDRESS_SYNTAX_CHECKER_TOP_DEFINES_SVH
`define MAIL_ADDRESS_SYNTAX_CHECKER_TOP_DEFINES_SVH

// same-cycle implication under reset
`define MASC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under reset
`define MASC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/masc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// masc_pkg
// constants, codes and character class functions of the address checker
// ---------------------------------------------------------------------------
package masc_pkg;

	// part limits
	localparam logic [6:0] LOCAL_MAX  = 7'd64;
	localparam logic [8:0] DOMAIN_MAX = 9'd255;
	localparam logic [6:0] LABEL_MAX  = 7'd63;

	// counter saturation values
	localparam logic [15:0] TOTAL_SAT  = 16'hFFFF;
	localparam logic [6:0]  LOCAL_SAT  = 7'h7F;
	localparam logic [8:0]  DOMAIN_SAT = 9'h1FF;
	localparam logic [6:0]  LABEL_SAT  = 7'h7F;
	localparam logic [1:0]  AT_SAT     = 2'd2;

	// reset value of the length limit register
	localparam logic [15:0] MAX_ADDR_RESET = 16'd254;

	// special characters
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_HYPHEN = 8'h2D;
	localparam logic [7:0] CH_COLON  = 8'h3A;

	// class of the previous byte
	typedef enum logic [1:0] {
		CLS_NONE   = 2'd0,
		CLS_DOT    = 2'd1,
		CLS_HYPHEN = 2'd2,
		CLS_OTHER  = 2'd3
	} char_cls_t;

	// reported error class, lowest wins
	typedef enum logic [1:0] {
		ERR_OK     = 2'd0,
		ERR_SHAPE  = 2'd1,
		ERR_LOCAL  = 2'd2,
		ERR_DOMAIN = 2'd3
	} err_cls_t;

	function automatic logic is_alnum(input logic [7:0] b);
		logic r;
		case (b) inside
			[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic is_hex(input logic [7:0] b);
		logic r;
		case (b) inside
			[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// letters, digits and the rfc atext specials
	function automatic logic is_atext(input logic [7:0] b);
		logic r;
		case (b) inside
			[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
			8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B, 8'h2D,
			8'h2F, 8'h3D, 8'h3F, 8'h5E, 8'h5F, 8'h60, 8'h7B, 8'h7C, 8'h7D,
			8'h7E: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

/* hdl/mail_address_syntax_checker_top.sv */
`timescale 1ns / 1ps
// an accepted last byte reaches its verdict via the input register, then the result register
// throughput: one byte per cycle while not stalled, set by the update of the running flags
// a verdict waiting in the result register does not stop bytes that produce none
// reset: asynchronous, clears all running state and the pipeline; limit returns to 254
// ---------------------------------------------------------------------------
// mail_address_syntax_checker_top
// streaming syntax check of one mail address, one byte per transaction,
// one verdict transaction on the last byte
// ---------------------------------------------------------------------------
module mail_address_syntax_checker_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	// byte channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  addr_byte,
	input  logic        last_byte,
	// verdict channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        valid_res,
	output logic [1:0]  error_class,
	output logic [6:0]  local_length,
	output logic [7:0]  domain_length
);
	import masc_pkg::*;

	logic [15:0] max_addr_q;

	// input stage
	logic        vld_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        adv_s1;
	logic        take_in;

	// running state
	logic [1:0]  at_q;
	logic [15:0] total_q;
	logic [6:0]  local_q;
	logic [8:0]  domain_q;
	logic [6:0]  label_q;
	char_cls_t   prev_q;
	logic        lit_mode_q, lit_closed_q, has_sep_q;
	logic        shape_err_q, local_err_q, domain_err_q;

	// next state
	logic [1:0]  at_d;
	logic [15:0] total_d;
	logic [6:0]  local_d;
	logic [8:0]  domain_d;
	logic [6:0]  label_d;
	char_cls_t   prev_d;
	logic        lit_mode_d, lit_closed_d, has_sep_d;
	logic        shape_err_d, local_err_d, domain_err_d;
	logic        shape_fin, domain_fin;
	err_cls_t    cls_d;

	// result register
	logic        out_vld_q;
	logic        res_ok_q;
	err_cls_t    res_cls_q;
	logic [6:0]  res_local_q;
	logic [7:0]  res_domain_q;

	// length limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_addr_q <= MAX_ADDR_RESET;
		end else if (cfg_wr_en) begin
			max_addr_q <= cfg_wr_data;
		end
	end

	// handshake: a non-final byte never waits on the result register
	assign adv_s1   = vld_s1 && (!last_s1 || !out_vld_q || !out_stall);
	assign take_in  = in_valid && !in_stall;
	assign in_stall = vld_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take_in) begin
			vld_s1 <= 1'b1;
		end else if (adv_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= addr_byte;
			last_s1 <= last_byte;
		end
	end

	// per-byte rule update and final verdict
	always_comb begin
		at_d         = at_q;
		total_d      = total_q;
		local_d      = local_q;
		domain_d     = domain_q;
		label_d      = label_q;
		prev_d       = prev_q;
		lit_mode_d   = lit_mode_q;
		lit_closed_d = lit_closed_q;
		has_sep_d    = has_sep_q;
		shape_err_d  = shape_err_q;
		local_err_d  = local_err_q;
		domain_err_d = domain_err_q;

		// total length
		if (total_q >= max_addr_q) shape_err_d = 1'b1;
		if (total_q != TOTAL_SAT) total_d = total_q + 16'd1;

		if (byte_s1 == CH_AT) begin
			if (at_q == 2'd0) begin
				if (local_q == 7'd0) shape_err_d = 1'b1;
				if (prev_q == CLS_DOT) local_err_d = 1'b1;
				prev_d = CLS_NONE;
			end else begin
				shape_err_d = 1'b1;
			end
			if (at_q < AT_SAT) at_d = at_q + 2'd1;
		end else if (at_q == 2'd0) begin
			// local part
			if (local_q >= LOCAL_MAX) local_err_d = 1'b1;
			if (local_q != LOCAL_SAT) local_d = local_q + 7'd1;
			if (byte_s1 == CH_DOT) begin
				if (prev_q == CLS_NONE || prev_q == CLS_DOT) local_err_d = 1'b1;
				prev_d = CLS_DOT;
			end else begin
				if (!is_atext(byte_s1)) local_err_d = 1'b1;
				prev_d = CLS_OTHER;
			end
		end else begin
			// domain part
			if (domain_q >= DOMAIN_MAX) domain_err_d = 1'b1;
			if (domain_q != DOMAIN_SAT) domain_d = domain_q + 9'd1;
			if (domain_q == 9'd0 && byte_s1 == CH_LBRACK) begin
				lit_mode_d = 1'b1;
				prev_d     = CLS_OTHER;
			end else if (lit_mode_q) begin
				if (lit_closed_q) begin
					domain_err_d = 1'b1;
				end else if (byte_s1 == CH_RBRACK) begin
					lit_closed_d = 1'b1;
				end else if (byte_s1 == CH_COLON || byte_s1 == CH_DOT) begin
					has_sep_d = 1'b1;
				end else if (!is_hex(byte_s1)) begin
					domain_err_d = 1'b1;
				end
			end else if (byte_s1 == CH_DOT) begin
				if (label_q == 7'd0 || prev_q == CLS_HYPHEN) domain_err_d = 1'b1;
				label_d = 7'd0;
				prev_d  = CLS_DOT;
			end else begin
				if (byte_s1 == CH_HYPHEN) begin
					if (label_q == 7'd0) domain_err_d = 1'b1;
					prev_d = CLS_HYPHEN;
				end else begin
					if (!is_alnum(byte_s1)) domain_err_d = 1'b1;
					prev_d = CLS_OTHER;
				end
				if (label_q >= LABEL_MAX) domain_err_d = 1'b1;
				if (label_q != LABEL_SAT) label_d = label_q + 7'd1;
			end
		end

		// end-of-address checks
		shape_fin  = shape_err_d;
		domain_fin = domain_err_d;
		if (at_d == 2'd0 || domain_d == 9'd0) begin
			shape_fin = 1'b1;
		end else if (lit_mode_d) begin
			if (!lit_closed_d || !has_sep_d) domain_fin = 1'b1;
		end else if (label_d == 7'd0 || prev_d == CLS_HYPHEN) begin
			domain_fin = 1'b1;
		end
		// the above only feeds the verdict; state is cleared after a last byte

		if (shape_fin)         cls_d = ERR_SHAPE;
		else if (local_err_d)  cls_d = ERR_LOCAL;
		else if (domain_fin)   cls_d = ERR_DOMAIN;
		else                   cls_d = ERR_OK;
	end

	// running state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_q         <= 2'd0;
			total_q      <= 16'd0;
			local_q      <= 7'd0;
			domain_q     <= 9'd0;
			label_q      <= 7'd0;
			prev_q       <= CLS_NONE;
			lit_mode_q   <= 1'b0;
			lit_closed_q <= 1'b0;
			has_sep_q    <= 1'b0;
			shape_err_q  <= 1'b0;
			local_err_q  <= 1'b0;
			domain_err_q <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				at_q         <= 2'd0;
				total_q      <= 16'd0;
				local_q      <= 7'd0;
				domain_q     <= 9'd0;
				label_q      <= 7'd0;
				prev_q       <= CLS_NONE;
				lit_mode_q   <= 1'b0;
				lit_closed_q <= 1'b0;
				has_sep_q    <= 1'b0;
				shape_err_q  <= 1'b0;
				local_err_q  <= 1'b0;
				domain_err_q <= 1'b0;
			end else begin
				at_q         <= at_d;
				total_q      <= total_d;
				local_q      <= local_d;
				domain_q     <= domain_d;
				label_q      <= label_d;
				prev_q       <= prev_d;
				lit_mode_q   <= lit_mode_d;
				lit_closed_q <= lit_closed_d;
				has_sep_q    <= has_sep_d;
				shape_err_q  <= shape_err_d;
				local_err_q  <= local_err_d;
				domain_err_q <= domain_err_d;
			end
		end
	end

	// verdict valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	// verdict payload
	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			res_ok_q     <= (cls_d == ERR_OK);
			res_cls_q    <= cls_d;
			res_local_q  <= (cls_d == ERR_OK) ? local_d : 7'd0;
			res_domain_q <= (cls_d == ERR_OK) ? domain_d[7:0] : 8'd0;
		end
	end

	assign out_valid     = out_vld_q;
	assign valid_res     = res_ok_q;
	assign error_class   = res_cls_q;
	assign local_length  = res_local_q;
	assign domain_length = res_domain_q;

endmodule

/* hdl/masc_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// masc_checker
// port-level checks of the verdict channel, bound to the top level
// ---------------------------------------------------------------------------
`include "mail_address_syntax_checker_top_defines.svh"

module masc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        valid_res,
	input logic [1:0]  error_class,
	input logic [6:0]  local_length,
	input logic [7:0]  domain_length
);
	import masc_pkg::*;

	// a stalled verdict transaction holds
	`MASC_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(valid_res) && $stable(error_class) && $stable(local_length) && $stable(domain_length), "verdict changed while stalled")

	// pass flag and error class agree
	`MASC_ASSERT_NOW(a_cls, clk, arst_n, out_valid, valid_res == (error_class == ERR_OK), "pass flag disagrees with error class")

	// rejected addresses report no lengths
	`MASC_ASSERT_NOW(a_rej_len, clk, arst_n, out_valid && !valid_res, local_length == 7'd0 && domain_length == 8'd0, "lengths reported on a rejected address")

	// accepted addresses have nonempty parts within limits
	`MASC_ASSERT_NOW(a_ok_len, clk, arst_n, out_valid && valid_res, local_length != 7'd0 && local_length <= LOCAL_MAX && domain_length != 8'd0, "part lengths out of range on a passed address")

endmodule

bind mail_address_syntax_checker_top masc_checker u_masc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.valid_res     (valid_res),
	.error_class   (error_class),
	.local_length  (local_length),
	.domain_length (domain_length)
);
